FILE: hdl/tehp_pkg.sv
// ----------------------------------------------------------------------------
// Tiered eviction hint policy package
// Shared constants, codes and the control/status types that pass between the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tehp_pkg;

  // Table geometry. Both entry counts are powers of two.
  localparam int HINT_ENTRIES    = 65536;
  localparam int COUNTER_ENTRIES = 16384;
  localparam int PAGE_SHIFT      = 21;

  localparam int HINT_AW = $clog2(HINT_ENTRIES);
  localparam int CNT_AW  = $clog2(COUNTER_ENTRIES);
  localparam int CLR_AW  = (HINT_AW > CNT_AW) ? HINT_AW : CNT_AW;

  // Counter hash shifts.
  localparam int HASH_SHIFT_LO = 6;
  localparam int HASH_SHIFT_HI = 18;

  localparam logic [7:0] COUNT_MAX = 8'd255;
  localparam logic [8:0] THRESHOLD_RESET = 9'd3;

  // Field widths.
  localparam int VA_W   = 64;
  localparam int STAT_W = 64;

  // Commands.
  localparam logic [1:0] CMD_ACTIVATE = 2'd0;
  localparam logic [1:0] CMD_SET_HINT = 2'd1;
  localparam logic [1:0] CMD_CLR_HINT = 2'd2;
  localparam logic [1:0] CMD_READ_STAT = 2'd3;

  // Tiers.
  localparam logic [1:0] TIER_DROP = 2'd0;
  localparam logic [1:0] TIER_PIN  = 2'd2;

  // Actions.
  localparam logic [1:0] ACT_STAY = 2'd0;
  localparam logic [1:0] ACT_HEAD = 2'd1;
  localparam logic [1:0] ACT_TAIL = 2'd2;

  // Event counters.
  localparam int EV_NUM        = 7;
  localparam int EV_ACTIVATE   = 0;
  localparam int EV_HINT_HIT   = 1;
  localparam int EV_TRASH_HEAD = 2;
  localparam int EV_HOT_TAIL   = 3;
  localparam int EV_COOL       = 4;
  localparam int EV_PROTECT    = 5;
  localparam int EV_HINT_MISS  = 6;

  typedef struct packed {
    logic              clear;      // clearing pass write
    logic [CLR_AW-1:0] clear_idx;
    logic              load;       // capture request and issue table reads
    logic              eval;       // resolve request and load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;                // result register holds a stalled result
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hdl/tehp_ctrl.sv
// ----------------------------------------------------------------------------
// Tiered eviction hint policy sequencer
// Runs the table clearing pass after reset, then steps each request through
// capture and evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module tehp_ctrl import tehp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  localparam logic [CLR_AW-1:0] CLR_LAST = '1;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [CLR_AW-1:0] clr;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr == CLR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + 1'b1;
    end
  end

  assign in_stall      = (state != ST_IDLE);
  assign cmd.clear     = (state == ST_CLEAR);
  assign cmd.clear_idx = clr;
  assign cmd.load      = (state == ST_IDLE) && in_valid;
  assign cmd.eval      = (state == ST_EVAL) && !sts.out_busy;

endmodule

`default_nettype wire

FILE: hdl/tehp_dp.sv
// ----------------------------------------------------------------------------
// Tiered eviction hint policy datapath
// Hint table, access counter table, event counters, threshold register and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tehp_dp import tehp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_cmd_t           cmd,
  output dp_sts_t                sts,
  input  wire logic              cfg_wr_en,
  input  wire logic [8:0]        cfg_wr_data,
  input  wire logic [1:0]        command,
  input  wire logic [VA_W-1:0]   block_va,
  input  wire logic [63:0]       chunk_address,
  input  wire logic [15:0]       page_number,
  input  wire logic [1:0]        tier_value,
  input  wire logic [2:0]        stat_index,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             action,
  output logic                   bypass,
  output logic                   hint_hit,
  output logic [STAT_W-1:0]      stat_value
);

  logic [2:0] hint_mem [HINT_ENTRIES];
  logic [7:0] cnt_mem  [COUNTER_ENTRIES];

  logic [8:0] threshold;

  // Captured request.
  logic [1:0]         cmd_q;
  logic               mapped_q;
  logic               va_in_range_q;
  logic               page_in_range_q;
  logic [HINT_AW-1:0] page_idx_q;
  logic [CNT_AW-1:0]  slot_q;
  logic [1:0]         tier_q;
  logic [2:0]         stat_q;
  logic [2:0]         hint_rd;
  logic [7:0]         cnt_rd;

  logic [STAT_W-1:0] ev [EV_NUM];

  // Read side of the capture cycle.
  logic [VA_W-PAGE_SHIFT-1:0] va_page;
  logic [63:0]                hash_word;
  logic [HINT_AW-1:0]         rd_hint_idx;
  logic [CNT_AW-1:0]          rd_slot;

  assign va_page     = block_va[VA_W-1:PAGE_SHIFT];
  assign hash_word   = (chunk_address >> HASH_SHIFT_LO) ^ (chunk_address >> HASH_SHIFT_HI);
  assign rd_slot     = hash_word[CNT_AW-1:0];
  assign rd_hint_idx = HINT_AW'(va_page);

  // Evaluation.
  logic              is_act;
  logic              hit;
  logic              miss;
  logic [8:0]        cnt_inc;
  logic [7:0]        cnt_new;
  logic              protect;
  logic [EV_NUM-1:0] ev_inc;
  logic [1:0]        action_next;
  logic              bypass_next;
  logic              hint_hit_next;
  logic [STAT_W-1:0] stat_next;

  always_comb begin
    is_act   = (cmd_q == CMD_ACTIVATE);
    hit      = is_act && mapped_q && va_in_range_q && hint_rd[2];
    miss     = is_act && mapped_q && !hit;
    cnt_inc  = {1'b0, cnt_rd} + 9'd1;
    cnt_new  = (cnt_rd == COUNT_MAX) ? COUNT_MAX : cnt_inc[7:0];
    protect  = miss && (cnt_inc >= threshold);

    ev_inc = '0;
    ev_inc[EV_ACTIVATE]   = is_act;
    ev_inc[EV_HINT_HIT]   = hit;
    ev_inc[EV_TRASH_HEAD] = hit && (hint_rd[1:0] == TIER_DROP);
    ev_inc[EV_HOT_TAIL]   = hit && (hint_rd[1:0] == TIER_PIN);
    ev_inc[EV_COOL]       = hit && (hint_rd[1:0] != TIER_DROP) && (hint_rd[1:0] != TIER_PIN);
    ev_inc[EV_PROTECT]    = protect;
    ev_inc[EV_HINT_MISS]  = miss;

    action_next = ACT_STAY;
    if (hit && (hint_rd[1:0] == TIER_DROP)) action_next = ACT_HEAD;
    else if (hit && (hint_rd[1:0] == TIER_PIN)) action_next = ACT_TAIL;
    else if (protect) action_next = ACT_TAIL;
    bypass_next   = hit || protect;
    hint_hit_next = hit;

    stat_next = '0;
    if ((cmd_q == CMD_READ_STAT) && (32'(stat_q) < EV_NUM)) begin
      stat_next = ev[stat_q];
    end
  end

  assign sts.out_busy = out_valid && out_stall;

  // Tables: a clearing pass after reset, then reads at capture and writes at
  // evaluation. One request is in flight, so a write lands before the next read.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      hint_mem[HINT_AW'(cmd.clear_idx)] <= '0;
    end else if (cmd.eval && page_in_range_q && (cmd_q == CMD_SET_HINT)) begin
      hint_mem[page_idx_q] <= {1'b1, tier_q};
    end else if (cmd.eval && page_in_range_q && (cmd_q == CMD_CLR_HINT)) begin
      hint_mem[page_idx_q] <= '0;
    end
    if (cmd.load) hint_rd <= hint_mem[rd_hint_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      cnt_mem[CNT_AW'(cmd.clear_idx)] <= '0;
    end else if (cmd.eval && miss) begin
      cnt_mem[slot_q] <= cnt_new;
    end
    if (cmd.load) cnt_rd <= cnt_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q           <= command;
      mapped_q        <= (block_va != '0);
      va_in_range_q   <= ({{PAGE_SHIFT{1'b0}}, va_page} < 64'(HINT_ENTRIES));
      page_in_range_q <= (32'(page_number) < HINT_ENTRIES);
      page_idx_q      <= (cmd.load && (command == CMD_ACTIVATE)) ? rd_hint_idx
                                                                  : HINT_AW'(page_number);
      slot_q          <= rd_slot;
      tier_q          <= tier_value;
      stat_q          <= stat_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < EV_NUM; i++) ev[i] <= '0;
    end else begin
      if (cfg_wr_en) threshold <= cfg_wr_data;
      if (cmd.eval) begin
        out_valid <= 1'b1;
        for (int i = 0; i < EV_NUM; i++) begin
          if (ev_inc[i]) ev[i] <= ev[i] + 1'b1;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      action     <= action_next;
      bypass     <= bypass_next;
      hint_hit   <= hint_hit_next;
      stat_value <= stat_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tiered_eviction_hint_policy_core.sv
// ----------------------------------------------------------------------------
// Tiered eviction hint policy core
// Places activated memory blocks in an LRU list from per-page tier hints and
// hashed access counters, and keeps event statistics.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_stall and are taken at an edge where
// in_valid is high and in_stall low. Every request (activate, set hint, clear
// hint, read statistic) gives exactly one result on out_valid/out_stall.
// A request is handled in two steps: capture, which reads the hint and counter
// tables (registered memory reads), and evaluation, which resolves it and
// writes back and loads the result register. A new request is taken only
// once the last one is evaluated, a pace set by the counter read-modify-write.
// A finished result waits in the output register; the next request is still
// taken, and its evaluation holds until the stalled result is taken.
// After reset the core clears both tables, one entry a cycle, with in_stall
// high; the threshold register resets to 3 and may be written through
// cfg_wr_en/cfg_wr_data at any time the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tiered_eviction_hint_policy_core import tehp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [8:0]        cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        command,
  input  wire logic [VA_W-1:0]   block_va,
  input  wire logic [63:0]       chunk_address,
  input  wire logic [15:0]       page_number,
  input  wire logic [1:0]        tier_value,
  input  wire logic [2:0]        stat_index,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             action,
  output logic                   bypass,
  output logic                   hint_hit,
  output logic [STAT_W-1:0]      stat_value
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tehp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tehp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .command       (command),
    .block_va      (block_va),
    .chunk_address (chunk_address),
    .page_number   (page_number),
    .tier_value    (tier_value),
    .stat_index    (stat_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .action        (action),
    .bypass        (bypass),
    .hint_hit      (hint_hit),
    .stat_value    (stat_value)
  );

endmodule

`default_nettype wire

FILE: tb/placement_checker.sv
// ----------------------------------------------------------------------------
// Placement checker
// Watches the request, result and threshold ports of the eviction hint policy
// core. It keeps its own copy of the hint table, access counters and event
// counters, predicts one result for every accepted request, and compares
// each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module placement_checker import tehp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [8:0]        cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        command,
  input  logic [63:0]       block_va,
  input  logic [63:0]       chunk_address,
  input  logic [15:0]       page_number,
  input  logic [1:0]        tier_value,
  input  logic [2:0]        stat_index,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        action,
  input  logic              bypass,
  input  logic              hint_hit,
  input  logic [63:0]       stat_value,
  output int unsigned       pending,
  output int unsigned       errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  action;
    logic        bypass;
    logic        hint_hit;
    logic [63:0] stat_value;
  } placement_t;

  // Hint entry: bit 2 marks a valid hint, bits 1:0 hold the tier.
  logic [2:0]  page_hints [HINT_ENTRIES];
  logic [7:0]  access_count [COUNTER_ENTRIES];
  logic [63:0] event_count [8];
  logic [8:0]  threshold;
  placement_t  placement_q [$];
  placement_t  predicted;

  function automatic logic [CNT_AW-1:0] counter_slot(input logic [63:0] chunk);
    logic [63:0] mixed;
    mixed = (chunk >> HASH_SHIFT_LO) ^ (chunk >> HASH_SHIFT_HI);
    return mixed[CNT_AW-1:0];
  endfunction

  task automatic place_request(output placement_t res);
    logic [63:0]       page;
    logic [2:0]        entry;
    logic [CNT_AW-1:0] slot;
    logic [8:0]        next_count;
    res = '0;
    case (command)
      CMD_ACTIVATE: begin
        event_count[EV_ACTIVATE] += 64'd1;
        if (block_va != 64'd0) begin
          page = block_va >> PAGE_SHIFT;
          entry = 3'b000;
          // Pages past the end of the table never carry a hint.
          if (page < HINT_ENTRIES) entry = page_hints[page[HINT_AW-1:0]];
          if (entry[2]) begin
            event_count[EV_HINT_HIT] += 64'd1;
            if (entry[1:0] == TIER_DROP) begin
              res.action = ACT_HEAD;
              event_count[EV_TRASH_HEAD] += 64'd1;
            end else if (entry[1:0] == TIER_PIN) begin
              res.action = ACT_TAIL;
              event_count[EV_HOT_TAIL] += 64'd1;
            end else begin
              event_count[EV_COOL] += 64'd1;
            end
            res.bypass = 1'b1;
            res.hint_hit = 1'b1;
          end else begin
            event_count[EV_HINT_MISS] += 64'd1;
            slot = counter_slot(chunk_address);
            // The comparison uses the unsaturated count, so it can reach 256.
            next_count = {1'b0, access_count[slot]} + 9'd1;
            if (access_count[slot] != COUNT_MAX) access_count[slot] = next_count[7:0];
            if (next_count >= threshold) begin
              res.action = ACT_TAIL;
              res.bypass = 1'b1;
              event_count[EV_PROTECT] += 64'd1;
            end
          end
        end
      end
      CMD_SET_HINT: page_hints[page_number] = {1'b1, tier_value};
      CMD_CLR_HINT: page_hints[page_number] = 3'b000;
      default: res.stat_value = event_count[stat_index];
    endcase
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  task automatic check_result();
    placement_t want;
    if (placement_q.size() == 0) begin
      errors++;
      $display("%0t: result with no request outstanding, expected none, actual %0h",
               $time, {action, bypass, hint_hit, stat_value});
    end else begin
      want = placement_q.pop_front();
      check_field("action", want.action, action);
      check_field("bypass", want.bypass, bypass);
      check_field("hint_hit", want.hint_hit, hint_hit);
      check_field("stat_value", want.stat_value, stat_value);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HINT_ENTRIES; i++) page_hints[i] = 3'b000;
      for (int i = 0; i < COUNTER_ENTRIES; i++) access_count[i] = 8'd0;
      for (int i = 0; i < 8; i++) event_count[i] = 64'd0;
      threshold = THRESHOLD_RESET;
      placement_q.delete();
      pending = 0;
      errors = 0;
    end else begin
      if (cfg_wr_en) threshold = cfg_wr_data;
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        place_request(predicted);
        placement_q.push_back(predicted);
      end
      pending = placement_q.size();
    end
  end

endmodule

FILE: tb/tiered_eviction_hint_policy_core_tb.sv
// ----------------------------------------------------------------------------
// Tiered eviction hint policy core testbench
// Drives directed and random requests through the core under several
// protection thresholds, with random idle and stall bursts on both channels,
// and lets the placement checker predict and compare every result.
// ----------------------------------------------------------------------------
module tiered_eviction_hint_policy_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tehp_pkg::*;

  localparam logic [1:0] TIER_NEUTRAL     = 2'd1;
  localparam logic [1:0] TIER_NEUTRAL_ALT = 2'd3;
  localparam logic [2:0] STAT_SPARE       = 3'd7;
  localparam int PHASE_ITEMS = 230;
  localparam int SAT_ITEMS   = 300;
  localparam int FINAL_ITEMS = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [8:0]  cfg_wr_data = 9'd0;
  logic        in_valid = 1'b0;
  logic [1:0]  command = CMD_ACTIVATE;
  logic [63:0] block_va = 64'd0;
  logic [63:0] chunk_address = 64'd0;
  logic [15:0] page_number = 16'd0;
  logic [1:0]  tier_value = 2'd0;
  logic [2:0]  stat_index = 3'd0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  action;
  logic        bypass;
  logic        hint_hit;
  logic [63:0] stat_value;

  logic        quiet = 1'b0;
  int          stall_left = 0;
  int unsigned pending;
  int unsigned errors;
  logic [15:0] page_pool [8];
  logic [63:0] chunk_pool [6];
  logic [63:0] sat_chunk;

  always #4 clk = ~clk;

  tiered_eviction_hint_policy_core u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .block_va(block_va),
    .chunk_address(chunk_address), .page_number(page_number), .tier_value(tier_value),
    .stat_index(stat_index), .out_valid(out_valid), .out_stall(out_stall),
    .action(action), .bypass(bypass), .hint_hit(hint_hit), .stat_value(stat_value)
  );

  placement_checker u_checker (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .block_va(block_va),
    .chunk_address(chunk_address), .page_number(page_number), .tier_value(tier_value),
    .stat_index(stat_index), .out_valid(out_valid), .out_stall(out_stall),
    .action(action), .bypass(bypass), .hint_hit(hint_hit), .stat_value(stat_value),
    .pending(pending), .errors(errors)
  );

  // Result-side stall bursts, each held while stall_left counts down.
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Stall is sampled at the falling edge, where it already holds the value
  // that the next rising edge will see.
  task automatic send(input logic [1:0] cmd, input logic [63:0] va,
                      input logic [63:0] chunk, input logic [15:0] page,
                      input logic [1:0] tier, input logic [2:0] sel);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    block_va <= va;
    chunk_address <= chunk;
    page_number <= page;
    tier_value <= tier;
    stat_index <= sel;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_threshold(input logic [8:0] value);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0 || in_stall) @(negedge clk);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Activations most often, on a small set of pages and chunks, so hints and
  // counters get hit again and again; the rest of the fields carry noise.
  task automatic send_random();
    int          pick;
    logic [1:0]  cmd;
    logic [63:0] va;
    logic [63:0] chunk;
    logic [15:0] page;
    va = {$urandom, $urandom};
    chunk = {$urandom, $urandom};
    page = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      cmd = CMD_ACTIVATE;
      case ($urandom_range(0, 9))
        0: va = 64'd0;
        1: ;
        default: va = {27'd0, page_pool[$urandom_range(0, 7)], va[20:0]};
      endcase
      if ($urandom_range(0, 1) == 0) chunk = chunk_pool[$urandom_range(0, 5)];
    end else begin
      if (pick < 65) cmd = CMD_SET_HINT;
      else if (pick < 75) cmd = CMD_CLR_HINT;
      else cmd = CMD_READ_STAT;
      if ($urandom_range(0, 4) != 0) page = page_pool[$urandom_range(0, 7)];
    end
    send(cmd, va, chunk, page, 2'($urandom), 3'($urandom));
  endtask

  initial begin
    logic [63:0] c0;
    logic [8:0]  levels [5];
    page_pool[0] = 16'd0;
    page_pool[1] = 16'hFFFF;
    page_pool[2] = 16'd5;
    for (int i = 3; i < 8; i++) page_pool[i] = 16'($urandom);
    for (int i = 0; i < 6; i++) chunk_pool[i] = {$urandom, $urandom};
    c0 = {$urandom, $urandom};
    sat_chunk = {$urandom, $urandom};
    levels[0] = 9'd0;
    levels[1] = 9'd1;
    levels[2] = 9'd511;
    levels[3] = 9'($urandom_range(2, 40));
    levels[4] = 9'($urandom_range(41, 255));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the reset threshold of three.
    send(CMD_READ_STAT, 64'd0, 64'd0, 16'd0, 2'd0, 3'(EV_ACTIVATE));
    send(CMD_ACTIVATE, 64'd0, c0, 16'd0, 2'd0, 3'd0);
    send(CMD_ACTIVATE, 64'd1, c0, 16'd0, 2'd0, 3'd0);
    // First page past the table, then the top of the address space.
    send(CMD_ACTIVATE, 64'h20_0000_0000, c0, 16'd0, 2'd0, 3'd0);
    send(CMD_ACTIVATE, '1, c0, 16'd0, 2'd0, 3'd0);
    send(CMD_ACTIVATE, 64'h1F_FFFF, '1, 16'd0, 2'd0, 3'd0);
    send(CMD_SET_HINT, 64'd0, 64'd0, 16'd0, TIER_DROP, 3'd0);
    send(CMD_ACTIVATE, 64'h1F_FFFF, c0, 16'd0, 2'd0, 3'd0);
    send(CMD_SET_HINT, 64'd0, 64'd0, 16'hFFFF, TIER_PIN, 3'd0);
    send(CMD_ACTIVATE, 64'h1F_FFFF_FFFF, c0, 16'd0, 2'd0, 3'd0);
    send(CMD_SET_HINT, 64'd0, 64'd0, 16'd5, TIER_NEUTRAL, 3'd0);
    send(CMD_ACTIVATE, {27'd0, 16'd5, 21'h0_1234}, c0, 16'd0, 2'd0, 3'd0);
    send(CMD_SET_HINT, 64'd0, 64'd0, 16'd5, TIER_NEUTRAL_ALT, 3'd0);
    send(CMD_ACTIVATE, {27'd0, 16'd5, 21'd0}, c0, 16'd0, 2'd0, 3'd0);
    send(CMD_CLR_HINT, 64'd0, 64'd0, 16'd5, 2'd0, 3'd0);
    send(CMD_ACTIVATE, {27'd0, 16'd5, 21'd0}, c0, 16'd0, 2'd0, 3'd0);
    for (int s = EV_HINT_HIT; s <= EV_HINT_MISS; s++)
      send(CMD_READ_STAT, 64'd0, 64'd0, 16'd0, 2'd0, 3'(s));
    send(CMD_READ_STAT, 64'd0, 64'd0, 16'd0, 2'd0, STAT_SPARE);

    foreach (levels[i]) begin
      quiet <= (i == 3);
      set_threshold(levels[i]);
      repeat (PHASE_ITEMS) send_random();
    end

    // Hammer one counter past saturation with the threshold at its highest
    // reachable value; the pages lie past the table, so every request misses.
    quiet <= 1'b0;
    set_threshold(9'd256);
    repeat (SAT_ITEMS)
      send(CMD_ACTIVATE, {1'b1, 31'($urandom), 32'($urandom)}, sat_chunk,
           16'($urandom), 2'($urandom), 3'($urandom));
    send(CMD_READ_STAT, 64'd0, 64'd0, 16'd0, 2'd0, 3'(EV_PROTECT));

    quiet <= 1'b1;
    set_threshold(THRESHOLD_RESET);
    repeat (FINAL_ITEMS) send_random();

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #3_200_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: tiered_eviction_hint_policy_core.f
hdl/tehp_pkg.sv
hdl/tehp_ctrl.sv
hdl/tehp_dp.sv
hdl/tiered_eviction_hint_policy_core.sv
tb/placement_checker.sv
tb/tiered_eviction_hint_policy_core_tb.sv
